// File: rtl/clcd_pkg.sv
// Shared types, constants and the initialisation sequence for the character LCD
// nibble interface. No dependencies.
package clcd_pkg;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned ROW_W      = 3;
   localparam int unsigned COL_W      = 7;
   localparam int unsigned BASE_W     = 7;
   localparam int unsigned WAIT_W     = 14;
   localparam int unsigned NIB_W      = 4;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned NUM_ROWS   = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POS  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3 = 2'd3;

   localparam logic [BASE_W-1:0] ROW0_RST = 7'd0;
   localparam logic [BASE_W-1:0] ROW1_RST = 7'd64;
   localparam logic [BASE_W-1:0] ROW2_RST = 7'd20;
   localparam logic [BASE_W-1:0] ROW3_RST = 7'd84;

   localparam logic [7:0] SET_DDRAM = 8'h80;

   localparam logic [WAIT_W-1:0] WAIT_POWER = 14'd15000;
   localparam logic [WAIT_W-1:0] WAIT_FS1   = 14'd4100;
   localparam logic [WAIT_W-1:0] WAIT_FS2   = 14'd100;
   localparam logic [WAIT_W-1:0] WAIT_CMD   = 14'd40;
   localparam logic [WAIT_W-1:0] WAIT_CLEAR = 14'd1600;
   localparam logic [WAIT_W-1:0] WAIT_NONE  = 14'd0;

   localparam logic [STEP_W-1:0] INIT_LAST = 4'd14;

   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] byte_val;
      logic       two_nib;
   } job_type;

   typedef struct packed {
      logic              strobe;
      logic              rs;
      logic [NIB_W-1:0]  nibble;
      logic [WAIT_W-1:0] wait_us;
      logic              last;
   } result_type;

   function automatic result_type init_step(input logic [STEP_W-1:0] idx);
      result_type r;
      r = '{strobe: 1'b1, rs: 1'b0, nibble: 4'h0, wait_us: WAIT_NONE, last: 1'b0};
      unique case (idx)
         4'd0: begin
            r.strobe  = 1'b0;
            r.wait_us = WAIT_POWER;
         end
         4'd1:  begin r.nibble = 4'h3; r.wait_us = WAIT_FS1; end
         4'd2:  begin r.nibble = 4'h3; r.wait_us = WAIT_FS2; end
         4'd3:  begin r.nibble = 4'h3; r.wait_us = WAIT_CMD; end
         4'd4:  begin r.nibble = 4'h2; r.wait_us = WAIT_CMD; end
         4'd5:  r.nibble = 4'h2;
         4'd6:  begin r.nibble = 4'h8; r.wait_us = WAIT_CMD; end
         4'd7:  r.nibble = 4'h0;
         4'd8:  begin r.nibble = 4'h8; r.wait_us = WAIT_CMD; end
         4'd9:  r.nibble = 4'h0;
         4'd10: begin r.nibble = 4'h1; r.wait_us = WAIT_CLEAR; end
         4'd11: r.nibble = 4'h0;
         4'd12: begin r.nibble = 4'h6; r.wait_us = WAIT_CMD; end
         4'd13: r.nibble = 4'h0;
         4'd14: begin r.nibble = 4'hC; r.wait_us = WAIT_CMD; r.last = 1'b1; end
         default: r.last = 1'b1;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/clcd_if.sv
// Request and response channel interfaces for the character LCD nibble interface.
// Depends on clcd_pkg.
interface clcd_req_if;
   logic                        valid;
   logic                        ready;
   logic [clcd_pkg::CMD_W-1:0]  command;
   logic [7:0]                  char_code;
   logic [clcd_pkg::COL_W-1:0]  column;
   logic [clcd_pkg::ROW_W-1:0]  row;

   modport source (output valid, command, char_code, column, row, input ready);
   modport sink   (input valid, command, char_code, column, row, output ready);
endinterface

interface clcd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         strobe_res;
   logic                         reg_select;
   logic [clcd_pkg::NIB_W-1:0]   nibble;
   logic [clcd_pkg::WAIT_W-1:0]  wait_us;
   logic                         last;

   modport source (output valid, strobe_res, reg_select, nibble, wait_us, last,
                   input ready);
   modport sink   (input valid, strobe_res, reg_select, nibble, wait_us, last,
                   output ready);
endinterface

// File: rtl/char_lcd_nibble_interface.sv
// Top level of the character LCD nibble interface: front end, job queue, back end.
// Depends on clcd_pkg, clcd_if, clcd_front, clcd_queue and clcd_back.
//
//  channel   direction  handshake          payload
//  req_chan  in         valid/ready        command, char_code, column, row
//  rsp_chan  out        valid/ready        strobe_res, reg_select, nibble, wait_us, last
//  csr_*     in         csr_we (no ready)  csr_index, csr_wdata (row base)
//
// One transaction out per cycle while rsp_chan is not stalled, from the back end's step
// counter; a character or position is two nibbles (one before init), init is 15 steps.
// Requests are taken every cycle while the queue has room (QUEUE_DEPTH jobs).
// Reset is synchronous; it restores row bases and clears 4-bit mode and the queue.
// A stalled rsp_chan holds the output register; the queue absorbs requests meanwhile.
module char_lcd_nibble_interface #(
   parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   clcd_req_if.sink                        req_chan,
   clcd_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [clcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [clcd_pkg::BASE_W-1:0]     csr_wdata
);

   logic                        q_ready, push, q_valid, pop, four_bit, out_valid;
   clcd_pkg::job_type           push_job, head;
   clcd_pkg::result_type        out_res;
   logic [clcd_pkg::STEP_W-1:0] step;

   assign req_chan.ready = q_ready;

   clcd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_chan.valid),
      .req_command   (req_chan.command),
      .req_char_code (req_chan.char_code),
      .req_column    (req_chan.column),
      .req_row       (req_chan.row),
      .q_ready       (q_ready),
      .push          (push),
      .job           (push_job),
      .four_bit_ff   (four_bit)
   );

   clcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .not_full  (q_ready),
      .pop       (pop),
      .not_empty (q_valid),
      .head      (head)
   );

   clcd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (q_valid),
      .job          (head),
      .pop          (pop),
      .out_valid_ff (out_valid),
      .out_ff       (out_res),
      .out_ready    (rsp_chan.ready),
      .step_ff      (step)
   );

   assign rsp_chan.valid      = out_valid;
   assign rsp_chan.strobe_res = out_res.strobe;
   assign rsp_chan.reg_select = out_res.rs;
   assign rsp_chan.nibble     = out_res.nibble;
   assign rsp_chan.wait_us    = out_res.wait_us;
   assign rsp_chan.last       = out_res.last;

   a_init_sets_mode: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.command == clcd_pkg::CMD_INIT)
      |=> four_bit)
      else $error("4-bit mode not set after init transaction");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step <= clcd_pkg::INIT_LAST)
      else $error("back end step counter out of range");

   a_step_only_init: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !head.is_init) |-> (step <= clcd_pkg::STEP_W'(1)))
      else $error("byte job stepped past its low nibble");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (out_valid && out_res.last && step == '0))
      else $error("queue popped without a final transaction loaded");

endmodule

// File: rtl/clcd_front.sv
// Front end: row base registers, mode tracking and classification of requests
// into queue jobs. Depends on clcd_pkg.
module clcd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [clcd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clcd_pkg::BASE_W-1:0]       csr_wdata,
   input  logic                              req_valid,
   input  logic [clcd_pkg::CMD_W-1:0]        req_command,
   input  logic [7:0]                        req_char_code,
   input  logic [clcd_pkg::COL_W-1:0]        req_column,
   input  logic [clcd_pkg::ROW_W-1:0]        req_row,
   input  logic                              q_ready,
   output logic                              push,
   output clcd_pkg::job_type                 job,
   output logic                              four_bit_ff
);

   logic [clcd_pkg::BASE_W-1:0] base_ff [clcd_pkg::NUM_ROWS];
   logic                        four_bit_in;
   logic [clcd_pkg::BASE_W-1:0] base;
   logic [7:0]                  addr;
   logic                        accept;

   assign accept = req_valid && q_ready;

   always_comb begin
      if (req_row[2]) begin
         base = base_ff[0];
      end else begin
         base = base_ff[req_row[1:0]];
      end
      addr = ({1'b0, base} + {1'b0, req_column}) | clcd_pkg::SET_DDRAM;
   end

   always_comb begin
      job  = '{is_init: 1'b0, rs: 1'b0, byte_val: addr, two_nib: four_bit_ff};
      push = 1'b0;
      unique case (req_command)
         clcd_pkg::CMD_INIT: begin
            job.is_init = 1'b1;
            push        = accept;
         end
         clcd_pkg::CMD_POS: push = accept;
         clcd_pkg::CMD_CHAR: begin
            job.rs       = 1'b1;
            job.byte_val = req_char_code;
            push         = accept;
         end
         default: push = 1'b0;
      endcase
   end

   assign four_bit_in = (accept && req_command == clcd_pkg::CMD_INIT) ? 1'b1 : four_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         four_bit_ff <= 1'b0;
         base_ff[0]  <= clcd_pkg::ROW0_RST;
         base_ff[1]  <= clcd_pkg::ROW1_RST;
         base_ff[2]  <= clcd_pkg::ROW2_RST;
         base_ff[3]  <= clcd_pkg::ROW3_RST;
      end else begin
         four_bit_ff <= four_bit_in;
         if (csr_we) begin
            unique case (csr_index)
               clcd_pkg::CSR_ROW0: base_ff[0] <= csr_wdata;
               clcd_pkg::CSR_ROW1: base_ff[1] <= csr_wdata;
               clcd_pkg::CSR_ROW2: base_ff[2] <= csr_wdata;
               clcd_pkg::CSR_ROW3: base_ff[3] <= csr_wdata;
            endcase
         end
      end
   end

endmodule

// File: rtl/clcd_queue.sv
// Short job queue between front and back end, register based.
// Depends on clcd_pkg.
module clcd_queue #(
   parameter int unsigned DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clcd_pkg::job_type push_job,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output clcd_pkg::job_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   clcd_pkg::job_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign not_full  = (cnt_ff != CNT_FULL);
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/clcd_back.sv
// Back end: steps through the head job, one nibble strobe or wait per cycle while
// the output register is not stalled, into that register. Depends on clcd_pkg.
module clcd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  clcd_pkg::job_type         job,
   output logic                      pop,
   output logic                      out_valid_ff,
   output clcd_pkg::result_type      out_ff,
   input  logic                      out_ready,
   output logic [clcd_pkg::STEP_W-1:0] step_ff
);

   logic [clcd_pkg::STEP_W-1:0] step_in;
   clcd_pkg::result_type        res;
   logic                        advance;
   logic                        out_valid_in;

   always_comb begin
      if (job.is_init) begin
         res = clcd_pkg::init_step(step_ff);
      end else if (job.two_nib && step_ff == '0) begin
         res = '{strobe: 1'b1, rs: job.rs, nibble: job.byte_val[7:4],
                 wait_us: clcd_pkg::WAIT_NONE, last: 1'b0};
      end else if (job.two_nib) begin
         res = '{strobe: 1'b1, rs: job.rs, nibble: job.byte_val[3:0],
                 wait_us: clcd_pkg::WAIT_CMD, last: 1'b1};
      end else begin
         res = '{strobe: 1'b1, rs: job.rs, nibble: job.byte_val[7:4],
                 wait_us: clcd_pkg::WAIT_CMD, last: 1'b1};
      end
   end

   assign advance = !out_valid_ff || out_ready;
   assign pop     = advance && job_valid && res.last;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = job_valid;
         if (job_valid) begin
            step_in = res.last ? '0 : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
      if (advance && job_valid) begin
         out_ff <= res;
      end
   end

endmodule
